/* hdl/assert_macros.svh */
// Assertion macros used by the RTL core of the date stepper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hdl/gds_pkg.sv */
package gds_pkg;

   localparam logic [13:0] YEAR_MAX    = 14'd9999;
   localparam logic [3:0]  MONTH_JAN   = 4'd1;
   localparam logic [3:0]  MONTH_FEB   = 4'd2;
   localparam logic [3:0]  MONTH_DEC   = 4'd12;
   localparam logic [4:0]  DAYS_WEEK   = 5'd7;
   localparam logic [6:0]  REM_LAST    = 7'd99;

   // Command codes.
   localparam logic [2:0] CMD_NEXT_DAY  = 3'd0;
   localparam logic [2:0] CMD_PREV_DAY  = 3'd1;
   localparam logic [2:0] CMD_NEXT_WEEK = 3'd2;
   localparam logic [2:0] CMD_PREV_WEEK = 3'd3;
   localparam logic [2:0] CMD_TERM_BACK = 3'd4;

   typedef struct packed {
      logic [13:0] y;
      logic [3:0]  m;
      logic [4:0]  d;
   } date_type;

   // Year split into centuries and the remainder within the century.
   typedef struct packed {
      logic [7:0] q;
      logic [6:0] r;
   } cent_type;

   typedef struct packed {
      logic backward;
      logic week;
   } step_ctl_type;

   typedef struct packed {
      date_type date;
      cent_type cent;
      logic     fail;
   } step_res_type;

   function automatic logic is_leap(input cent_type c);
      is_leap = (c.r[1:0] == 2'b00) && ((c.r != 7'd0) || (c.q[1:0] == 2'b00));
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      case (m) inside
         MONTH_FEB:                  month_len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:    month_len = 5'd30;
         default:                    month_len = 5'd31;
      endcase
   endfunction

endpackage

/* hdl/gds_step_unit.sv */
// One calendar step of one day or one week, forwards or backwards.
module gds_step_unit (
   input  gds_pkg::date_type     cur,
   input  gds_pkg::cent_type     cent,
   input  gds_pkg::step_ctl_type ctl,
   output gds_pkg::step_res_type res
);

   logic       leap;
   logic [4:0] n;
   logic [4:0] len_cur;
   logic [4:0] len_prev;
   logic [5:0] sum;

   always_comb begin
      leap     = gds_pkg::is_leap(cent);
      n        = ctl.week ? gds_pkg::DAYS_WEEK : 5'd1;
      len_cur  = gds_pkg::month_len(cur.m, leap);
      len_prev = gds_pkg::month_len(cur.m - 4'd1, leap);
      sum      = {1'b0, cur.d} + {1'b0, n};
      res.date = cur;
      res.cent = cent;
      res.fail = 1'b0;
      if (!ctl.backward) begin
         if (sum > {1'b0, len_cur}) begin
            res.date.d = 5'(sum - {1'b0, len_cur});
            if (cur.m == gds_pkg::MONTH_DEC) begin
               if (cur.y >= gds_pkg::YEAR_MAX) begin
                  res.fail = 1'b1;
               end
               res.date.y = cur.y + 14'd1;
               res.date.m = gds_pkg::MONTH_JAN;
               if (cent.r == gds_pkg::REM_LAST) begin
                  res.cent.r = 7'd0;
                  res.cent.q = cent.q + 8'd1;
               end else begin
                  res.cent.r = cent.r + 7'd1;
               end
            end else begin
               res.date.m = cur.m + 4'd1;
            end
         end else begin
            res.date.d = sum[4:0];
         end
      end else begin
         if (cur.d <= n) begin
            if (cur.m == gds_pkg::MONTH_JAN) begin
               // December always has 31 days, whatever the year.
               if (cur.y == 14'd0) begin
                  res.fail = 1'b1;
               end
               res.date.y = cur.y - 14'd1;
               res.date.m = gds_pkg::MONTH_DEC;
               res.date.d = 5'(6'd31 + {1'b0, cur.d} - {1'b0, n});
               if (cent.r == 7'd0) begin
                  res.cent.r = gds_pkg::REM_LAST;
                  res.cent.q = cent.q - 8'd1;
               end else begin
                  res.cent.r = cent.r - 7'd1;
               end
            end else begin
               res.date.m = cur.m - 4'd1;
               res.date.d = 5'({1'b0, len_prev} + {1'b0, cur.d} - {1'b0, n});
            end
         end else begin
            res.date.d = cur.d - n;
         end
      end
   end

endmodule

/* hdl/gregorian_date_stepper_core.sv */
// Gregorian date stepper.
// A transaction is offered on the req_ ports with start high and is taken at a rising
// edge where busy is low. It carries a date, a command (next or previous day, next or
// previous week, or back week_count-1 weeks) and a week count. The answer appears on the
// rsp_ ports for exactly one cycle, marked by rsp_valid; the receiver cannot stall it.
// busy stays high from acceptance until the result is shown, so at most one
// transaction is in flight. A single step unit moves the date by one day or one
// week per cycle; a valid day or week command takes one step and the term command
// up to MAX_WEEKS-1 steps. Before stepping, the sequencer splits the year into
// centuries (ST_SPLIT) and checks the input date (ST_CHECK). A new transaction may
// be taken in the cycle that shows a result. An invalid date, an unused command or
// a year leaving 0..9999 gives back the input date with rsp_range_error set.
// Synchronous reset returns the sequencer to idle and clears rsp_valid; the other
// registers are not reset, and each transaction reloads those that it uses.
`include "assert_macros.svh"

module gregorian_date_stepper_core #(
   parameter int MAX_WEEKS = 63
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_command,
   input  logic [13:0] req_year,
   input  logic [3:0]  req_month,
   input  logic [4:0]  req_day,
   input  logic [5:0]  req_week_count,
   output logic        rsp_valid,
   output logic [13:0] rsp_out_year,
   output logic [3:0]  rsp_out_month,
   output logic [4:0]  rsp_out_day,
   output logic        rsp_range_error
);

   localparam int CW = $clog2(MAX_WEEKS + 1);

   // Reciprocal of 100 scaled by 2^19; exact for every 14-bit year.
   localparam logic [26:0] RECIP_100 = 27'd5243;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SPLIT = 2'd1;
   localparam logic [1:0] ST_CHECK = 2'd2;
   localparam logic [1:0] ST_STEP  = 2'd3;

   logic [1:0]            state_ff, state_in;
   gds_pkg::date_type     src_ff, src_in;
   gds_pkg::date_type     work_ff, work_in;
   gds_pkg::cent_type     cent_ff, cent_in;
   logic [2:0]            cmd_ff, cmd_in;
   logic [CW-1:0]         weeks_ff, weeks_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   gds_pkg::date_type     rsp_date_ff, rsp_date_in;
   logic                  rsp_err_ff, rsp_err_in;

   gds_pkg::step_ctl_type ctl;
   gds_pkg::step_res_type step_res;
   logic [26:0]           q_prod;
   logic [14:0]           hundreds;
   logic [7:0]            weeks_sat;
   logic                  date_ok;
   logic [CW-1:0]         steps;

   gds_step_unit u_step (
      .cur  (work_ff),
      .cent (cent_ff),
      .ctl  (ctl),
      .res  (step_res)
   );

   always_comb begin
      // Direction and step size follow from the command alone.
      ctl.backward = (cmd_ff == gds_pkg::CMD_PREV_DAY) || (cmd_ff == gds_pkg::CMD_PREV_WEEK)
                     || (cmd_ff == gds_pkg::CMD_TERM_BACK);
      ctl.week     = (cmd_ff == gds_pkg::CMD_NEXT_WEEK) || (cmd_ff == gds_pkg::CMD_PREV_WEEK)
                     || (cmd_ff == gds_pkg::CMD_TERM_BACK);

      q_prod    = 27'(req_year) * RECIP_100;
      hundreds  = 15'({cent_ff.q, 6'b0}) + 15'({cent_ff.q, 5'b0}) + 15'({cent_ff.q, 2'b0});
      weeks_sat = ({2'b00, req_week_count} > 8'(MAX_WEEKS)) ? 8'(MAX_WEEKS)
                                                            : {2'b00, req_week_count};

      date_ok = (src_ff.y <= gds_pkg::YEAR_MAX) && (src_ff.m >= gds_pkg::MONTH_JAN)
                && (src_ff.m <= gds_pkg::MONTH_DEC) && (src_ff.d != 5'd0)
                && (src_ff.d <= gds_pkg::month_len(src_ff.m, gds_pkg::is_leap(cent_ff)))
                && (cmd_ff <= gds_pkg::CMD_TERM_BACK);

      if (cmd_ff == gds_pkg::CMD_TERM_BACK) begin
         steps = (weeks_ff <= CW'(1)) ? '0 : weeks_ff - CW'(1);
      end else begin
         steps = CW'(1);
      end

      state_in     = state_ff;
      src_in       = src_ff;
      work_in      = work_ff;
      cent_in      = cent_ff;
      cmd_in       = cmd_ff;
      weeks_in     = weeks_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_date_in  = rsp_date_ff;
      rsp_err_in   = rsp_err_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               src_in.y  = req_year;
               src_in.m  = req_month;
               src_in.d  = req_day;
               cmd_in    = req_command;
               weeks_in  = weeks_sat[CW-1:0];
               cent_in.q = q_prod[26:19];
               state_in  = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            // Remainder of the year within its century.
            cent_in.r = 7'(15'(src_ff.y) - hundreds);
            work_in   = src_ff;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            if (!date_ok || steps == '0) begin
               rsp_valid_in = 1'b1;
               rsp_date_in  = src_ff;
               rsp_err_in   = !date_ok;
               state_in     = ST_IDLE;
            end else begin
               cnt_in   = steps;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            work_in = step_res.date;
            cent_in = step_res.cent;
            cnt_in  = cnt_ff - CW'(1);
            if (step_res.fail) begin
               // The whole transaction is refused as soon as the year leaves range.
               rsp_valid_in = 1'b1;
               rsp_date_in  = src_ff;
               rsp_err_in   = 1'b1;
               state_in     = ST_IDLE;
            end else if (cnt_ff == CW'(1)) begin
               rsp_valid_in = 1'b1;
               rsp_date_in  = step_res.date;
               rsp_err_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      work_ff     <= work_in;
      cent_ff     <= cent_in;
      cmd_ff      <= cmd_in;
      weeks_ff    <= weeks_in;
      cnt_ff      <= cnt_in;
      rsp_date_ff <= rsp_date_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_year    = rsp_date_ff.y;
   assign rsp_out_month   = rsp_date_ff.m;
   assign rsp_out_day     = rsp_date_ff.d;
   assign rsp_range_error = rsp_err_ff;

   // An accepted transaction always occupies the block in the following cycle.
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // A result only follows a cycle in which the sequencer was working.
   `ASSERT_NEXT(a_rsp_after_work, clock, reset, !busy, !rsp_valid)
   // A refused transaction returns the stored source date unchanged.
   `ASSERT_IMPLIES(a_err_src, clock, reset, rsp_valid && rsp_range_error,
                   rsp_date_ff == src_ff)
   // While stepping, the remaining step count is never zero.
   `ASSERT_IMPLIES(a_step_cnt, clock, reset, state_ff == ST_STEP, cnt_ff != '0)
   // A successful result always carries a real month.
   `ASSERT_IMPLIES(a_month_ok, clock, reset, rsp_valid && !rsp_range_error,
                   rsp_out_month >= gds_pkg::MONTH_JAN && rsp_out_month <= gds_pkg::MONTH_DEC)

endmodule

/* tb/gregorian_date_stepper_checker.sv */
// Scoreboard for the date stepper. It watches both channels, works out the
// answer for every accepted transaction and checks each result against the
// oldest answer still waiting.
module gregorian_date_stepper_checker #(
   parameter int MAX_WEEKS = 63
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [2:0]  req_command,
   input  logic [13:0] req_year,
   input  logic [3:0]  req_month,
   input  logic [4:0]  req_day,
   input  logic [5:0]  req_week_count,
   input  logic        rsp_valid,
   input  logic [13:0] rsp_out_year,
   input  logic [3:0]  rsp_out_month,
   input  logic [4:0]  rsp_out_day,
   input  logic        rsp_range_error,
   output int          fail_count,
   output int          pending,
   output int          checked,
   output int          refused
);

   typedef struct packed {
      gds_pkg::date_type date;
      logic              range_error;
   } date_answer_type;

   date_answer_type expected_dates[$];
   int fail_tally    = 0;
   int checked_tally = 0;
   int refused_tally = 0;

   initial begin
      fail_count = 0;
      pending    = 0;
      checked    = 0;
      refused    = 0;
   end

   function automatic bit leap_year(input int y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int days_in_month(input int y, input int m);
      case (m)
         2:           return leap_year(y) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   // Moves the date one day; refuses when the year would leave 0..9999.
   function automatic bit move_one_day(inout int y, inout int m, inout int d,
                                       input bit backward);
      if (!backward) begin
         if (d + 1 > days_in_month(y, m)) begin
            if (m == 12) begin
               if (y >= gds_pkg::YEAR_MAX) return 1'b0;
               y = y + 1;
               m = 1;
            end else begin
               m = m + 1;
            end
            d = 1;
         end else begin
            d = d + 1;
         end
      end else begin
         if (d <= 1) begin
            if (m <= 1) begin
               if (y == 0) return 1'b0;
               y = y - 1;
               m = 12;
            end else begin
               m = m - 1;
            end
            d = days_in_month(y, m);
         end else begin
            d = d - 1;
         end
      end
      return 1'b1;
   endfunction

   function automatic date_answer_type step_date(input logic [2:0] cmd,
                                                 input logic [13:0] year,
                                                 input logic [3:0] month,
                                                 input logic [4:0] day,
                                                 input logic [5:0] week_count);
      date_answer_type answer;
      int y, m, d, weeks, steps;
      bit ok, backward;
      y = year;
      m = month;
      d = day;
      weeks = (week_count > MAX_WEEKS) ? MAX_WEEKS : week_count;
      steps = 0;
      backward = 1'b0;
      ok = (y <= gds_pkg::YEAR_MAX) && (m >= 1) && (m <= 12) && (d >= 1)
           && (d <= days_in_month(y, m));
      if (ok) begin
         case (cmd)
            gds_pkg::CMD_NEXT_DAY:  steps = 1;
            gds_pkg::CMD_PREV_DAY:  begin
               steps = 1;
               backward = 1'b1;
            end
            gds_pkg::CMD_NEXT_WEEK: steps = 7;
            gds_pkg::CMD_PREV_WEEK: begin
               steps = 7;
               backward = 1'b1;
            end
            gds_pkg::CMD_TERM_BACK: begin
               steps = (weeks > 1) ? (weeks - 1) * 7 : 0;
               backward = 1'b1;
            end
            default:                ok = 1'b0;
         endcase
      end
      for (int i = 0; i < steps && ok; i++)
         ok = move_one_day(y, m, d, backward);
      if (ok) begin
         answer.date.y = y[13:0];
         answer.date.m = m[3:0];
         answer.date.d = d[4:0];
      end else begin
         answer.date.y = year;
         answer.date.m = month;
         answer.date.d = day;
      end
      answer.range_error = !ok;
      return answer;
   endfunction

   always @(posedge clock) begin
      date_answer_type want;
      if (reset) begin
         expected_dates.delete();
      end else begin
         // The result is handled before any new acceptance in the same cycle,
         // so it is always matched against the older transaction.
         if (rsp_valid) begin
            if (expected_dates.size() == 0) begin
               $error("result with no transaction outstanding: %0d-%0d-%0d",
                      rsp_out_year, rsp_out_month, rsp_out_day);
               fail_tally++;
            end else begin
               want = expected_dates.pop_front();
               checked_tally++;
               if (rsp_range_error === 1'b1) refused_tally++;
               if (rsp_out_year !== want.date.y) begin
                  $error("out_year: expected %0d, actual %0d", want.date.y, rsp_out_year);
                  fail_tally++;
               end
               if (rsp_out_month !== want.date.m) begin
                  $error("out_month: expected %0d, actual %0d", want.date.m, rsp_out_month);
                  fail_tally++;
               end
               if (rsp_out_day !== want.date.d) begin
                  $error("out_day: expected %0d, actual %0d", want.date.d, rsp_out_day);
                  fail_tally++;
               end
               if (rsp_range_error !== want.range_error) begin
                  $error("range_error: expected %0d, actual %0d",
                         want.range_error, rsp_range_error);
                  fail_tally++;
               end
            end
         end
         if (start && !busy)
            expected_dates.push_back(step_date(req_command, req_year, req_month,
                                               req_day, req_week_count));
      end
      fail_count <= fail_tally;
      pending    <= expected_dates.size();
      checked    <= checked_tally;
      refused    <= refused_tally;
   end

endmodule

/* tb/gregorian_date_stepper_core_tb.sv */
// Top level of the date stepper testbench. It makes the clock and the reset,
// drives transactions into the block and gives the verdict. All prediction and
// comparison lives in the checker that sits beside the block.
module gregorian_date_stepper_core_tb;

   // The three command codes that the block does not use; each must be refused.
   localparam logic [2:0] CMD_SPARE_A = 3'd5;
   localparam logic [2:0] CMD_SPARE_B = 3'd6;
   localparam logic [2:0] CMD_SPARE_C = 3'd7;

   localparam int MAX_WEEKS     = 63;
   localparam int PHASE_ITEMS   = 500;
   // The settle time covers the slowest transaction plus a margin, so that a
   // stray late result is caught.
   localparam int SETTLE_CYCLES = 80;
   // The limit leaves a wide margin over roughly 1550 transactions of the slowest
   // kind, with long sender gaps on top.
   localparam int CYCLE_LIMIT   = 600000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_command    = '0;
   logic [13:0] req_year       = '0;
   logic [3:0]  req_month      = '0;
   logic [4:0]  req_day        = '0;
   logic [5:0]  req_week_count = '0;
   logic        rsp_valid;
   logic [13:0] rsp_out_year;
   logic [3:0]  rsp_out_month;
   logic [4:0]  rsp_out_day;
   logic        rsp_range_error;

   int fail_count, pending, checked, refused;
   int cycle_count = 0;
   int sent_per_command[8];

   always #4 clock = ~clock;

   gregorian_date_stepper_core #(.MAX_WEEKS(MAX_WEEKS)) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_year        (req_year),
      .req_month       (req_month),
      .req_day         (req_day),
      .req_week_count  (req_week_count),
      .rsp_valid       (rsp_valid),
      .rsp_out_year    (rsp_out_year),
      .rsp_out_month   (rsp_out_month),
      .rsp_out_day     (rsp_out_day),
      .rsp_range_error (rsp_range_error)
   );

   gregorian_date_stepper_checker #(.MAX_WEEKS(MAX_WEEKS)) checker_inst (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_year        (req_year),
      .req_month       (req_month),
      .req_day         (req_day),
      .req_week_count  (req_week_count),
      .rsp_valid       (rsp_valid),
      .rsp_out_year    (rsp_out_year),
      .rsp_out_month   (rsp_out_month),
      .rsp_out_day     (rsp_out_day),
      .rsp_range_error (rsp_range_error),
      .fail_count      (fail_count),
      .pending         (pending),
      .checked         (checked),
      .refused         (refused)
   );

   // Watchdog. A hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL gregorian_date_stepper_core");
         $finish;
      end
   end

   // Offers one transaction and returns at the edge where it is taken. The
   // caller decides in that same time step whether start stays high for the
   // next transaction or drops for a gap, so start is never assigned twice.
   task automatic issue_request(input logic [2:0] cmd, input logic [13:0] year,
                                input logic [3:0] month, input logic [4:0] day,
                                input logic [5:0] week_count);
      req_command    <= cmd;
      req_year       <= year;
      req_month      <= month;
      req_day        <= day;
      req_week_count <= week_count;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      sent_per_command[cmd]++;
   endtask

   // Idles the sender for a random stretch. While start is low the request
   // ports carry rubbish, which the block must ignore.
   task automatic sender_gap(input int idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         start          <= 1'b0;
         req_command    <= 3'($urandom);
         req_year       <= 14'($urandom);
         req_month      <= 4'($urandom);
         req_day        <= 5'($urandom);
         req_week_count <= 6'($urandom);
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   // Holds the sender off until every outstanding transaction has answered.
   // The first edge is waited for so that a transaction taken in this very
   // time step is already counted by the checker.
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Builds one random transaction. Most are well-formed dates, chosen so
   // that month ends, year ends, century years and both ends of the year
   // range turn up often; a small share is raw noise on every field.
   task automatic random_request();
      logic [2:0]  cmd;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [5:0]  week_count;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 8) begin
         cmd        = 3'($urandom);
         year       = 14'($urandom);
         month      = 4'($urandom);
         day        = 5'($urandom);
         week_count = 6'($urandom);
      end else begin
         cmd = (pick < 12) ? 3'($urandom_range(CMD_SPARE_C, CMD_SPARE_A))
                           : 3'($urandom_range(gds_pkg::CMD_TERM_BACK,
                                               gds_pkg::CMD_NEXT_DAY));
         case ($urandom_range(4))
            0:       year = 14'($urandom_range(3));
            1:       year = 14'(gds_pkg::YEAR_MAX - $urandom_range(3));
            2:       year = 14'(100 * $urandom_range(99));
            default: year = 14'($urandom_range(gds_pkg::YEAR_MAX));
         endcase
         case ($urandom_range(5))
            0:       month = gds_pkg::MONTH_JAN;
            1:       month = gds_pkg::MONTH_FEB;
            2:       month = gds_pkg::MONTH_DEC;
            default: month = 4'($urandom_range(12, 1));
         endcase
         // Days late in the month sometimes run past its end; those dates
         // are invalid and must be refused.
         pick = $urandom_range(99);
         if (pick < 55)
            day = 5'($urandom_range(28, 1));
         else if (pick < 85)
            day = 5'($urandom_range(31, 27));
         else
            day = 5'd1;
         // Short term steps dominate so that the long ones do not eat the run.
         week_count = ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                               : 6'($urandom_range(9));
      end
      issue_request(cmd, year, month, day, week_count);
   endtask

   initial begin
      int idle_pct[3];
      idle_pct = '{36, 77, 0};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed transactions: carries and borrows across month and year,
      // the leap rule in its three forms, both ends of the year range, the
      // term command's small and largest week counts, invalid dates and the
      // unused commands.
      issue_request(gds_pkg::CMD_NEXT_DAY,  14'd2023, gds_pkg::MONTH_DEC, 5'd31, 6'd0);
      issue_request(gds_pkg::CMD_NEXT_DAY,  14'd2024, gds_pkg::MONTH_FEB, 5'd28, 6'd0);
      issue_request(gds_pkg::CMD_NEXT_DAY,  14'd1900, gds_pkg::MONTH_FEB, 5'd28, 6'd0);
      issue_request(gds_pkg::CMD_NEXT_DAY,  14'd2000, gds_pkg::MONTH_FEB, 5'd29, 6'd0);
      issue_request(gds_pkg::CMD_NEXT_DAY,  gds_pkg::YEAR_MAX, gds_pkg::MONTH_DEC, 5'd31,
                    6'd63);
      issue_request(gds_pkg::CMD_PREV_DAY,  14'd0,    gds_pkg::MONTH_JAN, 5'd1,  6'd0);
      issue_request(gds_pkg::CMD_PREV_DAY,  14'd2024, 4'd3,               5'd1,  6'd0);
      issue_request(gds_pkg::CMD_PREV_DAY,  14'd2100, 4'd3,               5'd1,  6'd0);
      issue_request(gds_pkg::CMD_NEXT_WEEK, gds_pkg::YEAR_MAX, gds_pkg::MONTH_DEC, 5'd24,
                    6'd0);
      issue_request(gds_pkg::CMD_NEXT_WEEK, gds_pkg::YEAR_MAX, gds_pkg::MONTH_DEC, 5'd25,
                    6'd0);
      issue_request(gds_pkg::CMD_PREV_WEEK, 14'd0,    gds_pkg::MONTH_JAN, 5'd8,  6'd0);
      issue_request(gds_pkg::CMD_PREV_WEEK, 14'd0,    gds_pkg::MONTH_JAN, 5'd7,  6'd0);
      issue_request(gds_pkg::CMD_TERM_BACK, 14'd2024, 4'd9,               5'd30, 6'd0);
      issue_request(gds_pkg::CMD_TERM_BACK, 14'd2024, 4'd9,               5'd30, 6'd1);
      issue_request(gds_pkg::CMD_TERM_BACK, 14'd2024, 4'd9,               5'd30, 6'd2);
      issue_request(gds_pkg::CMD_TERM_BACK, 14'd2024, 4'd9,               5'd30, 6'd63);
      issue_request(gds_pkg::CMD_TERM_BACK, 14'd0,    4'd3,               5'd1,  6'd63);
      issue_request(gds_pkg::CMD_NEXT_DAY,  14'd2024, 4'd0,               5'd10, 6'd0);
      issue_request(gds_pkg::CMD_NEXT_DAY,  14'd2024, 4'd15,              5'd10, 6'd0);
      issue_request(gds_pkg::CMD_PREV_DAY,  14'd2024, 4'd5,               5'd0,  6'd0);
      issue_request(gds_pkg::CMD_NEXT_DAY,  14'd2023, 4'd4,               5'd31, 6'd0);
      issue_request(gds_pkg::CMD_NEXT_DAY,  14'd2023, gds_pkg::MONTH_FEB, 5'd29, 6'd0);
      issue_request(gds_pkg::CMD_NEXT_DAY,  14'h3fff, gds_pkg::MONTH_JAN, 5'd1,  6'd0);
      issue_request(CMD_SPARE_A,            14'd2024, 4'd6,               5'd15, 6'd3);
      issue_request(CMD_SPARE_B,            14'd2024, 4'd6,               5'd15, 6'd3);
      issue_request(CMD_SPARE_C,            14'd2024, 4'd6,               5'd15, 6'd3);

      // Random transactions in three phases: a lightly idling sender, a
      // heavily idling one, then back-to-back. Between phases the sender
      // waits for every outstanding result to come back.
      for (int phase = 0; phase < 3; phase++) begin
         drain_results();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            random_request();
            sender_gap(idle_pct[phase]);
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d next-day, %0d previous-day, %0d next-week, %0d previous-week,",
               sent_per_command[gds_pkg::CMD_NEXT_DAY],
               sent_per_command[gds_pkg::CMD_PREV_DAY],
               sent_per_command[gds_pkg::CMD_NEXT_WEEK],
               sent_per_command[gds_pkg::CMD_PREV_WEEK]);
      $display("%0d term-back and %0d unused-command transactions; %0d results, %0d refused.",
               sent_per_command[gds_pkg::CMD_TERM_BACK],
               sent_per_command[CMD_SPARE_A] + sent_per_command[CMD_SPARE_B]
               + sent_per_command[CMD_SPARE_C], checked, refused);
      if (fail_count == 0)
         $display("PASS gregorian_date_stepper_core");
      else
         $display("FAIL gregorian_date_stepper_core");
      $finish;
   end

endmodule

/* gregorian_date_stepper_core.f */
+incdir+hdl
hdl/gds_pkg.sv
hdl/gds_step_unit.sv
hdl/gregorian_date_stepper_core.sv
tb/gregorian_date_stepper_checker.sv
tb/gregorian_date_stepper_core_tb.sv
